>>> rtl/fca_pkg.sv
// Package for the file allocation table core.
// Types, status and operation codes, sequencer states. No dependencies.
package fca_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_REMOVE = 3'd1,
    OP_APPEND = 3'd2,
    OP_FREE   = 3'd3,
    OP_NEXT   = 3'd4,
    OP_FIRST  = 3'd5,
    OP_FORMAT = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXISTS      = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_DIR_FULL    = 3'd3,
    ST_DISK_FULL   = 3'd4,
    ST_NOT_IN_FILE = 3'd5,
    ST_NOT_EMPTY   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_SCAN,
    S_DISPATCH,
    S_AL_RD,
    S_AL_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_FR_RD,
    S_FR_WAIT,
    S_OUT
  } fsm_t;

  localparam int NAME_W  = 48;
  localparam int BLOCK_W = 8;

endpackage

>>> rtl/fca_link_mem.sv
// Link table memory of the file allocation table core.
// One write port, one read port with registered data. Uses fca_pkg.
module fca_link_mem
  import fca_pkg::*;
#(
  parameter int NUM_BLOCKS = 256,
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [AW-1:0]      wdata,
  input  logic [AW-1:0]      raddr,
  output logic [AW-1:0]      rdata
);

  logic [AW-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fat_chain_allocator_core.sv
// Top level of the file allocation table core: directory, sequencer, link table.
// Depends on fca_pkg and fca_link_mem.
//
// Usage: one command word enters on in_valid/in_ready (kind, file_name,
// block_number); exactly one result word leaves on out_valid/out_ready
// (status, block_out). One command is in work at a time; in_ready is high only
// while the sequencer idles and the output register is empty.
// Timing: create, remove, first and unknown kinds scan the directory, one
// directory slot compared per cycle, then dispatch and output. Append, free
// and next add a walk of the file's chain through the link table, one
// memory read per link (S_WALK_WAIT or S_AL_WAIT, then S_WALK). Format
// sweeps the link table, one link entry written per cycle. A new command is
// taken the cycle after the result leaves.
// Reset: after rst_n the link table is rebuilt by the same sweep as a format,
// with in_ready low; cfg writes are taken meanwhile.
// first_data_block takes effect at the next format.
// Stall: the result holds in the output register until out_ready; no new
// command is taken until then.
module fat_chain_allocator_core
  import fca_pkg::*;
#(
  parameter int DIR_SLOTS  = 16,
  parameter int NUM_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [NAME_W-1:0]   in_file_name,
  input  logic [BLOCK_W-1:0]  in_block_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [BLOCK_W-1:0]  out_block_out,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  localparam int AW  = (NUM_BLOCKS > 256) ? $clog2(NUM_BLOCKS) : 8;
  localparam int SW  = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int SCW = $clog2(DIR_SLOTS + 1);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);

  fsm_t state_r, state_nxt;

  logic [7:0]          fdb_r;
  logic [AW-1:0]       free_head_r, free_head_nxt;
  logic [DIR_SLOTS-1:0] used_r, used_nxt;
  logic [NAME_W-1:0]   name_mem [DIR_SLOTS];
  logic [AW-1:0]       first_mem [DIR_SLOTS];

  op_t                 kind_r;
  logic [NAME_W-1:0]   fname_r;
  logic [AW-1:0]       bn_r;
  logic [SCW-1:0]      scan_r, scan_nxt;
  logic                hit_r, hit_nxt;
  logic [SW-1:0]       hit_slot_r, hit_slot_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [SW-1:0]       free_slot_r, free_slot_nxt;
  logic [AW-1:0]       first_r, first_nxt;
  logic [AW-1:0]       cur_r, cur_nxt, prev_r, prev_nxt, alloc_r, alloc_nxt;
  logic [CW-1:0]       steps_r, steps_nxt;
  logic [CW-1:0]       fidx_r, fidx_nxt;
  logic [AW-1:0]       fdb_eff_r, fdb_eff_nxt;
  logic                fmt_cmd_r;

  logic                ov_r, ov_nxt;
  logic [2:0]          st_r, st_nxt;
  logic [BLOCK_W-1:0]  bo_r, bo_nxt;

  logic                dir_we;
  logic [SW-1:0]       dir_waddr;
  logic [NAME_W-1:0]   dir_wname;
  logic [AW-1:0]       dir_wfirst;

  logic                lm_we;
  logic [AW-1:0]       lm_waddr, lm_wdata, lm_raddr, lm_rdata;

  logic                accept;
  logic [SW-1:0]       scan_idx;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_block_out = bo_r;
  assign scan_idx  = scan_r[SW-1:0];

  fca_link_mem #(.NUM_BLOCKS(NUM_BLOCKS), .AW(AW)) u_link (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .raddr (lm_raddr),
    .rdata (lm_rdata)
  );

  always_ff @(posedge clk) begin
    if (dir_we) begin
      name_mem[dir_waddr]  <= dir_wname;
      first_mem[dir_waddr] <= dir_wfirst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FMT;
      fdb_r       <= 8'd15;
      free_head_r <= '0;
      used_r      <= '0;
      ov_r        <= 1'b0;
      fidx_r      <= '0;
      fdb_eff_r   <= AW'(15);
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        fdb_r <= cfg_wdata;
      end
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
      ov_r        <= ov_nxt;
      fidx_r      <= fidx_nxt;
      fdb_eff_r   <= fdb_eff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= op_t'(in_kind);
      fname_r <= in_file_name;
      bn_r    <= AW'(in_block_number);
    end
    scan_r      <= scan_nxt;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_ok_r   <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    first_r     <= first_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    alloc_r     <= alloc_nxt;
    steps_r     <= steps_nxt;
    st_r        <= st_nxt;
    bo_r        <= bo_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    ov_nxt        = ov_r;
    fidx_nxt      = fidx_r;
    fdb_eff_nxt   = fdb_eff_r;
    scan_nxt      = scan_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    alloc_nxt     = alloc_r;
    steps_nxt     = steps_r;
    st_nxt        = st_r;
    bo_nxt        = bo_r;
    dir_we        = 1'b0;
    dir_waddr     = hit_slot_r;
    dir_wname     = fname_r;
    dir_wfirst    = '0;
    lm_we         = 1'b0;
    lm_waddr      = '0;
    lm_wdata      = '0;
    lm_raddr      = cur_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(in_kind) == OP_FORMAT) begin
            fidx_nxt    = '0;
            fdb_eff_nxt = (fdb_r < 8'd2) ? AW'(2) : AW'(fdb_r);
            state_nxt   = S_FMT;
          end else begin
            scan_nxt    = '0;
            hit_nxt     = 1'b0;
            free_ok_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_FMT: begin
        lm_we    = 1'b1;
        lm_waddr = AW'(fidx_r);
        if ((32'(fidx_r) >= 32'(fdb_eff_r)) && (fidx_r + CW'(1) < NB_C)) begin
          lm_wdata = AW'(fidx_r + CW'(1));
        end
        fidx_nxt = fidx_r + CW'(1);
        if (fidx_r == NB_C - CW'(1)) begin
          used_nxt      = '0;
          free_head_nxt = (32'(fdb_eff_r) < 32'(NUM_BLOCKS)) ? fdb_eff_r : '0;
          state_nxt     = S_IDLE;
          if (fmt_cmd_r) begin
            st_nxt = ST_OK;
            bo_nxt = '0;
            ov_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (used_r[scan_idx] && name_mem[scan_idx] == fname_r && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = scan_idx;
          first_nxt    = first_mem[scan_idx];
        end
        if (!used_r[scan_idx] && !free_ok_r) begin
          free_ok_nxt   = 1'b1;
          free_slot_nxt = scan_idx;
        end
        scan_nxt = scan_r + SCW'(1);
        if (scan_r == SCW'(DIR_SLOTS - 1)) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt    = ST_OK;
        bo_nxt    = '0;
        state_nxt = S_OUT;
        if (kind_r == OP_CREATE) begin
          if (hit_r) begin
            st_nxt = ST_EXISTS;
          end else if (!free_ok_r) begin
            st_nxt = ST_DIR_FULL;
          end else begin
            dir_we    = 1'b1;
            dir_waddr = free_slot_r;
            used_nxt[free_slot_r] = 1'b1;
          end
        end else if (kind_r == OP_NONE) begin
          st_nxt = ST_OK;
        end else if (!hit_r) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          case (kind_r)
            OP_REMOVE: begin
              if (first_r != '0) begin
                st_nxt = ST_NOT_EMPTY;
              end else begin
                used_nxt[hit_slot_r] = 1'b0;
              end
            end
            OP_FIRST: begin
              bo_nxt = BLOCK_W'(first_r);
            end
            OP_APPEND: begin
              if (free_head_r == '0) begin
                st_nxt = ST_DISK_FULL;
              end else begin
                alloc_nxt = free_head_r;
                lm_raddr  = free_head_r;
                state_nxt = S_AL_RD;
              end
            end
            default: begin
              cur_nxt   = first_r;
              prev_nxt  = '0;
              steps_nxt = '0;
              lm_raddr  = first_r;
              state_nxt = S_WALK;
            end
          endcase
        end
      end
      S_AL_RD: begin
        free_head_nxt = lm_rdata;
        lm_we    = 1'b1;
        lm_waddr = alloc_r;
        lm_wdata = '0;
        bo_nxt   = BLOCK_W'(alloc_r);
        if (first_r == '0) begin
          dir_we     = 1'b1;
          dir_wfirst = alloc_r;
          state_nxt  = S_OUT;
        end else begin
          cur_nxt   = first_r;
          steps_nxt = '0;
          state_nxt = S_AL_WAIT;
        end
      end
      S_AL_WAIT: begin
        lm_raddr  = cur_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (kind_r == OP_APPEND) begin
          if (lm_rdata != '0 && steps_r < NB_C) begin
            cur_nxt   = lm_rdata;
            steps_nxt = steps_r + CW'(1);
            state_nxt = S_AL_WAIT;
          end else begin
            lm_we     = 1'b1;
            lm_waddr  = cur_r;
            lm_wdata  = alloc_r;
            state_nxt = S_OUT;
          end
        end else begin
          if (cur_r == '0 || steps_r >= NB_C) begin
            st_nxt    = ST_NOT_IN_FILE;
            state_nxt = S_OUT;
          end else if (cur_r == bn_r) begin
            if (kind_r == OP_NEXT) begin
              bo_nxt    = BLOCK_W'(lm_rdata);
              state_nxt = S_OUT;
            end else begin
              if (prev_r == '0) begin
                dir_we     = 1'b1;
                dir_wfirst = lm_rdata;
              end else begin
                lm_we    = 1'b1;
                lm_waddr = prev_r;
                lm_wdata = lm_rdata;
              end
              state_nxt = S_FR_RD;
            end
          end else begin
            prev_nxt  = cur_r;
            cur_nxt   = lm_rdata;
            steps_nxt = steps_r + CW'(1);
            state_nxt = S_WALK_WAIT;
          end
        end
      end
      S_WALK_WAIT: begin
        lm_raddr  = cur_r;
        state_nxt = S_WALK;
      end
      S_FR_RD: begin
        lm_we         = 1'b1;
        lm_waddr      = bn_r;
        lm_wdata      = free_head_r;
        free_head_nxt = bn_r;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cmd_r <= 1'b0;
    end else if (accept) begin
      fmt_cmd_r <= (op_t'(in_kind) == OP_FORMAT);
    end else if (state_r == S_FMT && state_nxt == S_IDLE) begin
      fmt_cmd_r <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE && !ov_r))
    else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r)
    else $error("result lost under stall");
  a_fh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(free_head_r) < 32'(NUM_BLOCKS)))
    else $error("free head out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept)
    else $error("accept while busy");

endmodule

>>> tb/sv/fat_chain_allocator_core_checker.sv
// Checker for the file allocation table core: watches both channels, predicts
// each result word from a local directory and link table, and compares.
// Depends on fca_pkg.
`timescale 1ns / 100ps
module fat_chain_allocator_core_checker
  import fca_pkg::*;
#(
  parameter int DIR_SLOTS  = 16,
  parameter int NUM_BLOCKS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [NAME_W-1:0]  in_file_name,
  input  logic [BLOCK_W-1:0] in_block_number,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [BLOCK_W-1:0] out_block_out,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [2:0]         status;
    logic [BLOCK_W-1:0] blk;
  } result_t;

  result_t             expected_q[$];
  logic [7:0]          fdb_reg;
  logic                dir_used[DIR_SLOTS];
  logic [NAME_W-1:0]   dir_name[DIR_SLOTS];
  logic [BLOCK_W-1:0]  dir_first[DIR_SLOTS];
  logic [BLOCK_W-1:0]  links[NUM_BLOCKS];
  logic [BLOCK_W-1:0]  free_list_head;

  assign pending = expected_q.size();

  function automatic void rebuild_table();
    int fdb;
    fdb = (fdb_reg < 2) ? 2 : fdb_reg;
    for (int i = 0; i < DIR_SLOTS; i++) begin
      dir_used[i] = 1'b0;
      dir_name[i] = '0;
      dir_first[i] = '0;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      links[i] = (i >= fdb && i + 1 < NUM_BLOCKS) ? BLOCK_W'(i + 1) : '0;
    end
    free_list_head = (fdb < NUM_BLOCKS) ? BLOCK_W'(fdb) : '0;
  endfunction

  function automatic bit find_in_chain(int head, int target, output int prev_blk);
    int b, prev, steps;
    b = head;
    prev = 0;
    steps = 0;
    prev_blk = 0;
    while (b != 0 && b < NUM_BLOCKS && steps < NUM_BLOCKS) begin
      if (b == target) begin
        prev_blk = prev;
        return 1'b1;
      end
      prev = b;
      b = links[b];
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic result_t run_command(op_t op, logic [NAME_W-1:0] nm, int bn);
    result_t r;
    int slot, prev, alloc, b, steps;
    r.status = ST_OK;
    r.blk = '0;
    slot = -1;
    for (int i = DIR_SLOTS - 1; i >= 0; i--) begin
      if (dir_used[i] && dir_name[i] == nm) slot = i;
    end
    case (op)
      OP_CREATE: begin
        if (slot >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          r.status = ST_DIR_FULL;
          for (int i = 0; i < DIR_SLOTS; i++) begin
            if (!dir_used[i] && r.status == ST_DIR_FULL) begin
              dir_used[i] = 1'b1;
              dir_name[i] = nm;
              dir_first[i] = '0;
              r.status = ST_OK;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else if (dir_first[slot] != 0) r.status = ST_NOT_EMPTY;
        else dir_used[slot] = 1'b0;
      end
      OP_APPEND: begin
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (free_list_head == 0) begin
          r.status = ST_DISK_FULL;
        end else begin
          alloc = free_list_head;
          free_list_head = links[alloc];
          links[alloc] = '0;
          if (dir_first[slot] == 0) begin
            dir_first[slot] = BLOCK_W'(alloc);
          end else begin
            b = dir_first[slot];
            steps = 0;
            while (links[b] != 0 && steps < NUM_BLOCKS) begin
              b = links[b];
              steps++;
            end
            links[b] = BLOCK_W'(alloc);
          end
          r.blk = BLOCK_W'(alloc);
        end
      end
      OP_FREE: begin
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (!find_in_chain(dir_first[slot], bn, prev)) begin
          r.status = ST_NOT_IN_FILE;
        end else begin
          if (prev == 0) dir_first[slot] = links[bn];
          else links[prev] = links[bn];
          links[bn] = free_list_head;
          free_list_head = BLOCK_W'(bn);
        end
      end
      OP_NEXT: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else if (!find_in_chain(dir_first[slot], bn, prev)) r.status = ST_NOT_IN_FILE;
        else r.blk = links[bn];
      end
      OP_FIRST: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else r.blk = dir_first[slot];
      end
      OP_FORMAT: rebuild_table();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      fdb_reg = 8'd15;
      rebuild_table();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          run_command(op_t'(in_kind), in_file_name, in_block_number));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word status=%0d block=%0d", $realtime,
                     out_status, out_block_out);
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_status || want.blk !== out_block_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch status exp %0d got %0d, block exp %0d got %0d",
                       $realtime, want.status, out_status, want.blk, out_block_out);
          end
        end
      end
      if (cfg_we) fdb_reg = cfg_wdata;
    end
  end

endmodule

>>> tb/sv/fat_chain_allocator_core_test.sv
// Top of the file allocation table core testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on fca_pkg, the core and the checker module.
`timescale 1ns / 100ps
module fat_chain_allocator_core_test
  import fca_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 380;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_kind = '0;
  logic [NAME_W-1:0]  in_file_name = '0;
  logic [BLOCK_W-1:0] in_block_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [BLOCK_W-1:0] out_block_out;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = '0;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 hold_off = 1'b0;
  logic [NAME_W-1:0]  name_pool[6];

  always #2 clk = ~clk;

  fat_chain_allocator_core dut (.*);

  fat_chain_allocator_core_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** fat_chain_allocator_core: FAILED **");
      $finish;
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b0;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_word(op_t op, logic [NAME_W-1:0] nm, logic [BLOCK_W-1:0] bn);
    in_valid <= 1'b1;
    in_kind <= op;
    in_file_name <= nm;
    in_block_number <= bn;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * 256 + 40) @(negedge clk);
  endtask

  task automatic write_fdb(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int sel;
    op_t op;
    logic [NAME_W-1:0] nm;
    logic [BLOCK_W-1:0] bn;
    sel = $urandom_range(0, 99);
    if (sel < 20) op = OP_CREATE;
    else if (sel < 30) op = OP_REMOVE;
    else if (sel < 55) op = OP_APPEND;
    else if (sel < 70) op = OP_FREE;
    else if (sel < 85) op = OP_NEXT;
    else if (sel < 95) op = OP_FIRST;
    else if (sel < 98) op = OP_FORMAT;
    else op = OP_NONE;
    if ($urandom_range(0, 9) == 0) nm = NAME_W'({$urandom, $urandom});
    else nm = name_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 9) == 0) bn = BLOCK_W'($urandom);
    else bn = BLOCK_W'($urandom_range(0, 40));
    send_word(op, nm, bn);
  endtask

  initial begin
    int burst;
    for (int i = 0; i < 6; i++) name_pool[i] = NAME_W'({$urandom, $urandom});
    name_pool[0] = '0;
    name_pool[1] = '1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    write_fdb(8'd0);

    send_word(OP_FORMAT, '0, '0);
    send_word(OP_CREATE, name_pool[0], '0);
    send_word(OP_CREATE, name_pool[0], '0);
    send_word(OP_CREATE, name_pool[1], '0);
    send_word(OP_APPEND, name_pool[0], '0);
    send_word(OP_APPEND, name_pool[0], '0);
    send_word(OP_APPEND, name_pool[1], '0);
    send_word(OP_APPEND, name_pool[0], '0);
    send_word(OP_NEXT, name_pool[0], 8'd2);
    send_word(OP_NEXT, name_pool[0], 8'd0);
    send_word(OP_NEXT, name_pool[0], 8'hff);
    send_word(OP_FREE, name_pool[0], 8'd3);
    send_word(OP_FREE, name_pool[0], 8'd4);
    send_word(OP_FIRST, name_pool[0], '0);
    send_word(OP_REMOVE, name_pool[0], '0);
    send_word(OP_REMOVE, name_pool[2], '0);
    send_word(OP_APPEND, name_pool[2], '0);
    send_word(OP_NONE, name_pool[1], 8'hff);
    for (int i = 0; i < 17; i++) send_word(OP_CREATE, NAME_W'({$urandom, $urandom}), '0);
    drain();

    write_fdb(8'd255);
    send_word(OP_FORMAT, '0, '0);
    send_word(OP_CREATE, name_pool[3], '0);
    send_word(OP_APPEND, name_pool[3], '0);
    send_word(OP_FIRST, name_pool[3], '0);
    drain();

    write_fdb(8'd250);
    send_word(OP_FORMAT, '0, '0);

    hold_off = 1'b1;
    for (int n = 0; n < NUM_RANDOM;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) random_word();
      if ($urandom_range(0, 1) == 0) pause_sender();
      if (n >= 120 && n < 141) begin
        drain();
        write_fdb(8'($urandom_range(2, 60)));
        send_word(OP_FORMAT, '0, '0);
        n = 141;
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("** fat_chain_allocator_core: PASSED **");
    end else begin
      $display("** fat_chain_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fca_pkg.sv
rtl/fca_link_mem.sv
rtl/fat_chain_allocator_core.sv
tb/sv/fat_chain_allocator_core_checker.sv
tb/sv/fat_chain_allocator_core_test.sv
